/* rtl/core/sffm_pkg.sv */
// sffm_pkg: shared types, constants and table functions of the sine-sum flicker modulator
// microcode word layout, program table, sine table entry builder
// no dependencies
`timescale 1ns / 1ps

package sffm_pkg;

	localparam int unsigned PC_W = 4;

	localparam logic [16:0] FULL_Q16       = 17'd65536;
	localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
	localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
	localparam logic [63:0] ONE_Q30        = 64'd1 << 30;
	localparam int unsigned N14            = 24;
	localparam logic [31:0] R14            = 32'd1198372;
	localparam logic signed [20:0] SUM_BIAS = 21'sd458759;

	localparam logic REG_AMOUNT = 1'b0;
	localparam logic REG_SPEED  = 1'b1;

	localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
	localparam logic [PC_W-1:0] PC_ARG  = 4'd6;
	localparam logic [PC_W-1:0] PC_EMIT = 4'd15;

	typedef enum logic [3:0] {
		OP_START,
		OP_MUL_DS,
		OP_MUL_INV,
		OP_DMOD,
		OP_DNEG,
		OP_PHASE,
		OP_ARG,
		OP_MUL_Y,
		OP_IDX,
		OP_ACC,
		OP_BIAS,
		OP_MUL_V,
		OP_QUOT,
		OP_MUL_U,
		OP_MODV,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		CND_NEXT,
		CND_IDLE,
		CND_LOOP,
		CND_EMIT
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cnd;
		logic [PC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic amount_zero;
		logic loop_last;
		logic out_free;
	} stat_t;

	function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
		ctrl_t w;
		w = '{op: OP_START, cnd: CND_IDLE, target: PC_EMIT};
		case (pc)
			4'd0:  w = '{op: OP_START,   cnd: CND_IDLE, target: PC_EMIT};
			4'd1:  w = '{op: OP_MUL_DS,  cnd: CND_NEXT, target: PC_IDLE};
			4'd2:  w = '{op: OP_MUL_INV, cnd: CND_NEXT, target: PC_IDLE};
			4'd3:  w = '{op: OP_DMOD,    cnd: CND_NEXT, target: PC_IDLE};
			4'd4:  w = '{op: OP_DNEG,    cnd: CND_NEXT, target: PC_IDLE};
			4'd5:  w = '{op: OP_PHASE,   cnd: CND_NEXT, target: PC_IDLE};
			4'd6:  w = '{op: OP_ARG,     cnd: CND_NEXT, target: PC_IDLE};
			4'd7:  w = '{op: OP_MUL_Y,   cnd: CND_NEXT, target: PC_IDLE};
			4'd8:  w = '{op: OP_IDX,     cnd: CND_NEXT, target: PC_IDLE};
			4'd9:  w = '{op: OP_ACC,     cnd: CND_LOOP, target: PC_ARG};
			4'd10: w = '{op: OP_BIAS,    cnd: CND_NEXT, target: PC_IDLE};
			4'd11: w = '{op: OP_MUL_V,   cnd: CND_NEXT, target: PC_IDLE};
			4'd12: w = '{op: OP_QUOT,    cnd: CND_NEXT, target: PC_IDLE};
			4'd13: w = '{op: OP_MUL_U,   cnd: CND_NEXT, target: PC_IDLE};
			4'd14: w = '{op: OP_MODV,    cnd: CND_NEXT, target: PC_IDLE};
			4'd15: w = '{op: OP_EMIT,    cnd: CND_EMIT, target: PC_IDLE};
			default: w = '{op: OP_START, cnd: CND_IDLE, target: PC_EMIT};
		endcase
		return w;
	endfunction

	// phase multipliers in tenths: 1.0, 2.7, 4.3
	function automatic logic [5:0] tap_mult(logic [1:0] j);
		logic [5:0] k;
		case (j)
			2'd0: k = 6'd10;
			2'd1: k = 6'd27;
			2'd2: k = 6'd43;
			default: k = 6'd10;
		endcase
		return k;
	endfunction

	function automatic logic [3:0] tap_mod(logic [1:0] j);
		logic [3:0] k;
		case (j)
			2'd0: k = 4'd0;
			2'd1: k = 4'd7;
			2'd2: k = 4'd3;
			default: k = 4'd0;
		endcase
		return k;
	endfunction

	function automatic logic [3:0] mod10_6(logic [5:0] v);
		logic [5:0] r;
		r = v;
		if (r >= 6'd40)
			r = r - 6'd40;
		if (r >= 6'd20)
			r = r - 6'd20;
		if (r >= 6'd10)
			r = r - 6'd10;
		return r[3:0];
	endfunction

	// one quarter-wave entry, Q1.16, from a Horner-form series in Q30
	function automatic logic [16:0] sine_entry(int unsigned q, int unsigned tb);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] sub;
		logic [63:0] s;
		logic [63:0] e;
		x   = (64'(q) * HALF_PI_Q30) >> tb;
		x2  = (x * x) >> 30;
		t   = ONE_Q30;
		sub = ((x2 * t) >> 30) / 64'd210;
		t   = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
		sub = ((x2 * t) >> 30) / 64'd156;
		t   = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
		sub = ((x2 * t) >> 30) / 64'd110;
		t   = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
		sub = ((x2 * t) >> 30) / 64'd72;
		t   = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
		sub = ((x2 * t) >> 30) / 64'd42;
		t   = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
		sub = ((x2 * t) >> 30) / 64'd20;
		t   = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
		sub = ((x2 * t) >> 30) / 64'd6;
		t   = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
		s   = (x * t) >> 30;
		e   = (s + 64'd8192) >> 14;
		if (e > 64'(FULL_Q16))
			e = 64'(FULL_Q16);
		return e[16:0];
	endfunction

endpackage

/* rtl/core/sffm_tick_if.sv */
// sffm_tick_if: input channel of the flicker modulator, one time tick per transfer
// no dependencies
`timescale 1ns / 1ps

interface sffm_tick_if;
	logic        valid;
	logic        ready;
	logic [15:0] elapsed_time;

	modport source(output valid, output elapsed_time, input ready);
	modport sink(input valid, input elapsed_time, output ready);
endinterface

/* rtl/core/sffm_result_if.sv */
// sffm_result_if: output channel of the flicker modulator, one modifier per transfer
// no dependencies
`timescale 1ns / 1ps

interface sffm_result_if;
	logic        valid;
	logic        ready;
	logic [16:0] flicker_modifier;

	modport source(output valid, output flicker_modifier, input ready);
	modport sink(input valid, input flicker_modifier, output ready);
endinterface

/* rtl/core/sffm_sequencer.sv */
// sffm_sequencer: step counter and microprogram table, issues one control word per cycle
// depends on sffm_pkg
`timescale 1ns / 1ps

module sffm_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  sffm_pkg::stat_t stat,
	output sffm_pkg::ctrl_t ctrl
);

	logic [sffm_pkg::PC_W-1:0] pc_q;
	logic [sffm_pkg::PC_W-1:0] pc_next;

	always_comb begin
		ctrl = sffm_pkg::ucode(pc_q);
	end

	always_comb begin
		case (ctrl.cnd)
			sffm_pkg::CND_NEXT: pc_next = pc_q + 1'b1;
			sffm_pkg::CND_IDLE: begin
				if (!stat.in_valid)
					pc_next = pc_q;
				else if (stat.amount_zero)
					pc_next = ctrl.target;
				else
					pc_next = pc_q + 1'b1;
			end
			sffm_pkg::CND_LOOP: pc_next = stat.loop_last ? pc_q + 1'b1 : ctrl.target;
			sffm_pkg::CND_EMIT: pc_next = stat.out_free ? ctrl.target : pc_q;
			default: pc_next = sffm_pkg::PC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= sffm_pkg::PC_IDLE;
		else
			pc_q <= pc_next;
	end

endmodule

/* rtl/core/sffm_sine_rom.sv */
// sffm_sine_rom: quarter-wave sine table in Q1.16 with registered read
// depends on sffm_pkg for the entry builder
`timescale 1ns / 1ps

module sffm_sine_rom #(
	parameter int unsigned TABLE_BITS = 10
) (
	input  logic                  clk,
	input  logic [TABLE_BITS:0]   addr,
	output logic [16:0]           data
);

	localparam int unsigned DEPTH = (1 << TABLE_BITS) + 1;

	typedef logic [16:0] rom_arr_t [DEPTH];

	function automatic rom_arr_t build_rom();
		rom_arr_t r;
		for (int unsigned q = 0; q < DEPTH; q++)
			r[q] = sffm_pkg::sine_entry(q, TABLE_BITS);
		return r;
	endfunction

	localparam rom_arr_t ROM = build_rom();

	logic [16:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= ROM[addr];
	end

	assign data = data_q;

endmodule

/* rtl/core/sffm_datapath.sv */
// sffm_datapath: phase register, shared 32x32 multiplier and sine accumulation
// driven one control word per cycle by sffm_sequencer; depends on sffm_pkg, sffm_sine_rom
`timescale 1ns / 1ps

module sffm_datapath #(
	parameter int unsigned TABLE_BITS = 10,
	parameter int unsigned FRAC_BITS  = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sffm_pkg::ctrl_t ctrl,
	input  logic            start,
	input  logic [15:0]     dt,
	input  logic [16:0]     amount,
	input  logic [15:0]     speed,
	output logic [16:0]     modifier,
	output logic            loop_last
);

	localparam int unsigned PW     = FRAC_BITS + 4;
	localparam int unsigned MAG_W  = FRAC_BITS + 6;
	localparam int unsigned SHIFT  = 56 - FRAC_BITS;
	localparam int unsigned ARG_SH = FRAC_BITS - TABLE_BITS - 2;
	localparam int unsigned YW     = TABLE_BITS + 8;
	localparam int unsigned N10    = YW + 4;
	localparam int unsigned FKW    = FRAC_BITS + 6;

	localparam logic [63:0]       ROUND   = 64'd1 << (SHIFT - 1);
	localparam logic [PW-1:0]     WRAP    = PW'(10) << FRAC_BITS;
	localparam logic [31:0]       R10     = 32'((64'd1 << N10) / 10);
	localparam logic [TABLE_BITS:0] ROM_TOP = {1'b1, {TABLE_BITS{1'b0}}};

	logic [15:0]        dt_q;
	logic [63:0]        p_q;
	logic [PW-1:0]      d_q;
	logic [PW-1:0]      phase_q;
	logic [YW-1:0]      y_q;
	logic [1:0]         kidx_q;
	logic               sneg_q;
	logic signed [19:0] acc_q;
	logic [19:0]        v_q;
	logic [16:0]        u_q;
	logic [16:0]        mod_q;

	logic [15:0]        spd_mag;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        mul_p;
	logic [63:0]        rnd;
	logic [MAG_W-1:0]   mag;
	logic [PW-1:0]      d_mod;
	logic [PW-1:0]      d_neg;
	logic [PW:0]        sum_ph;
	logic [PW-1:0]      ph_next;
	logic [7:0]         ik;
	logic [3:0]         c10;
	logic [FKW-1:0]     fk;
	logic [YW-1:0]      y_next;
	logic [YW-1:0]      q0;
	logic [YW-1:0]      t10;
	logic [YW-1:0]      r10;
	logic [YW-1:0]      qq;
	logic [TABLE_BITS-1:0] pos;
	logic [TABLE_BITS:0]   rom_addr;
	logic [16:0]           rom_data;
	logic signed [19:0] sval;
	logic signed [19:0] sv;
	logic signed [19:0] wt;
	logic signed [20:0] vb;
	logic [16:0]        q14;
	logic [19:0]        t14;
	logic [19:0]        r14;
	logic [17:0]        u_raw;
	logic [33:0]        dr;
	logic [17:0]        depth;

	sffm_sine_rom #(
		.TABLE_BITS(TABLE_BITS)
	) u_rom (
		.clk (clk),
		.addr(rom_addr),
		.data(rom_data)
	);

	always_comb begin
		spd_mag = speed[15] ? (~speed + 16'd1) : speed;
		case (ctrl.op)
			sffm_pkg::OP_MUL_DS: begin
				mul_a = {16'd0, dt_q};
				mul_b = {16'd0, spd_mag};
			end
			sffm_pkg::OP_MUL_INV: begin
				mul_a = p_q[31:0];
				mul_b = sffm_pkg::INV_TWO_PI_Q32;
			end
			sffm_pkg::OP_MUL_Y: begin
				mul_a = {{(32-YW){1'b0}}, y_q};
				mul_b = R10;
			end
			sffm_pkg::OP_MUL_V: begin
				mul_a = {12'd0, v_q};
				mul_b = sffm_pkg::R14;
			end
			sffm_pkg::OP_MUL_U: begin
				mul_a = {15'd0, u_q};
				mul_b = {15'd0, amount};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// phase step: round to the phase grid, reduce modulo 10 turns, negate for a negative speed, add to the phase
	always_comb begin
		rnd     = p_q + ROUND;
		mag     = rnd[SHIFT +: MAG_W];
		d_mod   = {sffm_pkg::mod10_6(mag[FRAC_BITS +: 6]), mag[FRAC_BITS-1:0]};
		d_neg   = speed[15] ? ((d_q == '0) ? '0 : WRAP - d_q) : d_q;
		sum_ph  = {1'b0, phase_q} + {1'b0, d_q};
		ph_next = (sum_ph >= {1'b0, WRAP}) ? PW'(sum_ph - {1'b0, WRAP}) : sum_ph[PW-1:0];
	end

	// sine argument, only the table index bits of phase * k / 10
	always_comb begin
		ik     = phase_q[FRAC_BITS +: 4] * sffm_pkg::tap_mod(kidx_q);
		c10    = sffm_pkg::mod10_6(ik[5:0]);
		fk     = phase_q[FRAC_BITS-1:0] * sffm_pkg::tap_mult(kidx_q);
		y_next = ({{(YW-4){1'b0}}, c10} << (TABLE_BITS + 2)) + fk[ARG_SH +: YW];
	end

	always_comb begin
		q0       = p_q[N10 +: YW];
		t10      = (q0 << 3) + (q0 << 1);
		r10      = y_q - t10;
		qq       = q0 + {{(YW-1){1'b0}}, (r10 >= YW'(10))};
		pos      = qq[TABLE_BITS-1:0];
		rom_addr = qq[TABLE_BITS] ? (ROM_TOP - {1'b0, pos}) : {1'b0, pos};
	end

	always_comb begin
		sval = $signed({3'b000, rom_data});
		sv   = sneg_q ? -sval : sval;
		case (kidx_q)
			2'd0: wt = sv <<< 2;
			2'd1: wt = sv <<< 1;
			default: wt = sv;
		endcase
		vb = {acc_q[19], acc_q} + sffm_pkg::SUM_BIAS;
	end

	always_comb begin
		q14   = p_q[sffm_pkg::N14 +: 17];
		t14   = ({3'b000, q14} << 4) - ({3'b000, q14} << 1);
		r14   = v_q - t14;
		u_raw = {1'b0, q14} + {17'd0, (r14 >= 20'd14)};
		dr    = p_q[33:0] + 34'd32768;
		depth = dr[33:16];
		if (depth > {1'b0, sffm_pkg::FULL_Q16})
			depth = {1'b0, sffm_pkg::FULL_Q16};
	end

	always_ff @(posedge clk) begin
		if (start)
			dt_q <= dt;
		case (ctrl.op)
			sffm_pkg::OP_MUL_DS,
			sffm_pkg::OP_MUL_INV,
			sffm_pkg::OP_MUL_Y,
			sffm_pkg::OP_MUL_V,
			sffm_pkg::OP_MUL_U: p_q <= mul_p;
			sffm_pkg::OP_DMOD:  d_q <= d_mod;
			sffm_pkg::OP_DNEG:  d_q <= d_neg;
			sffm_pkg::OP_PHASE: acc_q <= '0;
			sffm_pkg::OP_ARG:   y_q <= y_next;
			sffm_pkg::OP_IDX:   sneg_q <= qq[TABLE_BITS+1];
			sffm_pkg::OP_ACC:   acc_q <= acc_q + wt;
			sffm_pkg::OP_BIAS:  v_q <= vb[19:0];
			sffm_pkg::OP_QUOT:
				u_q <= (u_raw > {1'b0, sffm_pkg::FULL_Q16}) ? sffm_pkg::FULL_Q16 : u_raw[16:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			mod_q   <= sffm_pkg::FULL_Q16;
			kidx_q  <= '0;
		end else begin
			case (ctrl.op)
				sffm_pkg::OP_PHASE: begin
					phase_q <= ph_next;
					kidx_q  <= '0;
				end
				sffm_pkg::OP_ACC:  kidx_q <= kidx_q + 2'd1;
				sffm_pkg::OP_MODV: mod_q <= 17'({1'b0, sffm_pkg::FULL_Q16} - depth);
				default: ;
			endcase
		end
	end

	assign modifier  = mod_q;
	assign loop_last = (kidx_q == 2'd2);

endmodule

/* rtl/core/sine_sum_flicker_modulator_core.sv */
// sine_sum_flicker_modulator_core: top level, APB register port, channels, output register
// depends on sffm_pkg, sffm_tick_if, sffm_result_if, sffm_sequencer, sffm_datapath
// a tick transfer runs the microprogram through to the emit step; with a zero amount it jumps straight to emit
// ticks are taken one at a time, only in the start step of the 16-step microprogram
// with its 3-pass sine loop; a result waiting in the output register holds the emit step
// reset: phase 0, modifier 1.0, amount and speed 0, no result pending
`timescale 1ns / 1ps

module sine_sum_flicker_modulator_core #(
	parameter int unsigned SINE_TABLE_BITS     = 10,
	parameter int unsigned PHASE_FRACTION_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	sffm_tick_if.sink            tick,
	sffm_result_if.source        result
);

	logic [16:0]     amount_q;
	logic [15:0]     speed_q;
	logic [16:0]     amount_sat;
	logic            out_valid_q;
	logic [16:0]     out_data_q;
	logic            start;
	logic            emit;
	logic            out_free;
	logic            loop_last;
	logic [16:0]     modifier;
	sffm_pkg::ctrl_t ctrl;
	sffm_pkg::stat_t stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amount_q <= '0;
			speed_q  <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == sffm_pkg::REG_AMOUNT)
				amount_q <= pwdata[16:0];
			else
				speed_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = (paddr[2] == sffm_pkg::REG_SPEED) ? {16'd0, speed_q} : {15'd0, amount_q};
	end

	assign amount_sat = (amount_q > sffm_pkg::FULL_Q16) ? sffm_pkg::FULL_Q16 : amount_q;

	assign tick.ready = (ctrl.op == sffm_pkg::OP_START);
	assign start      = tick.valid && tick.ready;
	assign out_free   = !out_valid_q || result.ready;
	assign emit       = (ctrl.op == sffm_pkg::OP_EMIT) && out_free;

	always_comb begin
		stat.in_valid    = tick.valid;
		stat.amount_zero = (amount_q == '0);
		stat.loop_last   = loop_last;
		stat.out_free    = out_free;
	end

	sffm_sequencer u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.ctrl  (ctrl)
	);

	sffm_datapath #(
		.TABLE_BITS(SINE_TABLE_BITS),
		.FRAC_BITS (PHASE_FRACTION_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.start    (start),
		.dt       (tick.elapsed_time),
		.amount   (amount_sat),
		.speed    (speed_q),
		.modifier (modifier),
		.loop_last(loop_last)
	);

	// output register, one transfer pending at most
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_data_q <= modifier;
	end

	assign result.valid            = out_valid_q;
	assign result.flicker_modifier = out_data_q;

endmodule
